// ===== design/source_text_tokenizer_core_macros.svh =====
// Assertion macros for the source text tokenizer checker.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define STTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define STTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sttc_pkg.sv =====
// Shared types, codes and the keyword tables of the source text tokenizer.
// Has no dependencies; used by the core and by its checker.
`default_nettype none

package sttc_pkg;

  // Widths of the result fields as they leave the block.
  localparam int FieldOffW = 20;
  localparam int FieldLineW = 16;

  // Token kinds.
  localparam logic [2:0] KIND_NAME    = 3'd0;
  localparam logic [2:0] KIND_NUM     = 3'd1;
  localparam logic [2:0] KIND_BRACKET = 3'd2;
  localparam logic [2:0] KIND_OPER    = 3'd3;
  localparam logic [2:0] KIND_STRING  = 3'd4;
  localparam logic [2:0] KIND_KEYWORD = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;
  localparam logic [2:0] KIND_NONE    = 3'd7;

  // Character classes.
  localparam logic [2:0] CLS_TXT     = 3'd0;
  localparam logic [2:0] CLS_NUM     = 3'd1;
  localparam logic [2:0] CLS_BRACKET = 3'd2;
  localparam logic [2:0] CLS_SPACE   = 3'd3;
  localparam logic [2:0] CLS_QUOTE   = 3'd4;
  localparam logic [2:0] CLS_OPER    = 3'd5;

  // Characters with a special meaning.
  localparam logic [7:0] CHAR_BLANK  = 8'h20;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SQUOTE = 8'd39;
  localparam logic [7:0] CHAR_DQUOTE = 8'd34;

  // Outcome of the word lookup.
  localparam logic [1:0] WORD_PLAIN = 2'd0;
  localparam logic [1:0] WORD_KEY   = 2'd1;
  localparam logic [1:0] WORD_OPER  = 2'd2;

  // Longest keyword; the text is compared as this many bytes, first byte on top.
  localparam int KwMaxLen = 8;
  localparam int KwCount = 21;
  localparam int OpCount = 3;

  localparam logic [63:0] KW_TEXT [KwCount] = '{
    {"let", 40'h0}, {"const", 24'h0}, {"if", 48'h0}, {"elseif", 16'h0},
    {"for", 40'h0}, {"while", 24'h0}, {"fn", 48'h0}, {"then", 32'h0},
    {"do", 48'h0}, {"end", 40'h0}, {"type", 32'h0}, {"from", 32'h0},
    {"number", 16'h0}, {"string", 16'h0}, {"bool", 32'h0}, {"void", 32'h0},
    {"return", 16'h0}, {"break", 24'h0}, {"continue"}, {"true", 32'h0},
    {"false", 24'h0}
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd3, 4'd5, 4'd2, 4'd6, 4'd3, 4'd5, 4'd2, 4'd4, 4'd2, 4'd3, 4'd4,
    4'd4, 4'd6, 4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd8, 4'd4, 4'd5
  };
  localparam logic [63:0] OP_TEXT [OpCount] = '{
    {"not", 40'h0}, {"and", 40'h0}, {"or", 48'h0}
  };
  localparam logic [3:0] OP_LEN [OpCount] = '{4'd3, 4'd3, 4'd2};

  // One result transaction, without its last flag.
  typedef struct packed {
    logic [2:0]            kind;
    logic [FieldOffW-1:0]  start;
    logic [FieldOffW-1:0]  len;
    logic [FieldLineW-1:0] line;
    logic [FieldLineW-1:0] col;
  } result_t;

  // Sorts a byte into its character class.
  function automatic logic [2:0] classify(logic [7:0] c);
    logic [2:0] cls;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
      cls = CLS_TXT;
    end else if (c >= "0" && c <= "9") begin
      cls = CLS_NUM;
    end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}") begin
      cls = CLS_BRACKET;
    end else if (c == CHAR_BLANK || c == 8'h09 || c == CHAR_LF || c == 8'h0D) begin
      cls = CLS_SPACE;
    end else if (c == CHAR_SQUOTE || c == CHAR_DQUOTE) begin
      cls = CLS_QUOTE;
    end else begin
      cls = CLS_OPER;
    end
    return cls;
  endfunction

  // Parallel match of a short token against both word lists. Bytes past the
  // token's length are zero, so whole-word equality plus length is enough.
  function automatic logic [1:0] word_class(logic [63:0] text, logic [3:0] len);
    logic [1:0] wc;
    wc = WORD_PLAIN;
    for (int i = 0; i < OpCount; i++) begin
      if (len == OP_LEN[i] && text == OP_TEXT[i]) wc = WORD_OPER;
    end
    for (int i = 0; i < KwCount; i++) begin
      if (len == KW_LEN[i] && text == KW_TEXT[i]) wc = WORD_KEY;
    end
    return wc;
  endfunction

endpackage

`default_nettype wire

// ===== design/source_text_tokenizer_core.sv =====
// Streaming source text tokenizer: one byte in, up to four token transactions out.
// Depends on sttc_pkg for kinds, character classes and the keyword tables.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one source byte and an end
//   flag that marks the final byte of a text. Output channel (out_valid_o /
//   out_stall_i) carries token transactions: kind, start offset, length, and
//   line and column at the point the token finished; run_last_o marks the last
//   transaction caused by one input byte.
//   One byte is held back as lookahead, so the tokens that a byte finishes come
//   out when the following byte arrives. The final byte flushes everything and
//   adds an end marker, after which the tokenizer is back in its reset state.
//   An accepted byte is held in the input register; once the result bank is
//   free its results are loaded into the bank and are offered from then.
//   Throughput: one byte per cycle while each byte yields at most one token and
//   the receiver does not stall; a byte with more results (at most four, on the
//   final byte) holds the input while the bank drains one per unstalled cycle.
//   A stalled receiver holds the current transaction; once the bank and the
//   input register are both full, in_stall_o rises.
//   Reset empties the input register and bank and clears all tokenizer state.
`default_nettype none

module source_text_tokenizer_core import sttc_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS = 16,
  parameter int KEYWORD_MAX_LEN = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            char_byte_i,
  input  wire logic                  end_of_text_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [2:0]                 token_kind_o,
  output logic [FieldOffW-1:0]       start_offset_o,
  output logic [FieldOffW-1:0]       token_length_o,
  output logic [FieldLineW-1:0]      line_number_o,
  output logic [FieldLineW-1:0]      column_number_o,
  output logic                       run_last_o
);

  localparam int IdxW = $clog2(KEYWORD_MAX_LEN);

  typedef struct packed {
    logic [7:0]                        held_char;
    logic                              held_valid;
    logic [2:0]                        kind;
    logic [OFFSET_BITS-1:0]            tok_start;
    logic [OFFSET_BITS-1:0]            tok_count;
    logic [KEYWORD_MAX_LEN-1:0][7:0]   prefix;
    logic [LINE_BITS-1:0]              line;
    logic [LINE_BITS-1:0]              col;
    logic [7:0]                        quote;
    logic                              comment;
    logic [OFFSET_BITS-1:0]            pos;
  } tok_state_t;

  typedef struct packed {
    tok_state_t st;
    logic       emit;
    result_t    res;
  } step_t;

  // State after reset and after the end of a text.
  function automatic tok_state_t state_init();
    tok_state_t s;
    s = '0;
    s.kind = KIND_NONE;
    s.line = LINE_BITS'(1);
    s.col = LINE_BITS'(1);
    s.quote = CHAR_BLANK;
    return s;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_inc(logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic tok_state_t clear_token(tok_state_t s);
    tok_state_t r;
    r = s;
    r.kind = KIND_NONE;
    r.tok_count = '0;
    r.prefix = '0;
    return r;
  endfunction

  // Adds a byte to the open token, keeping the first bytes for the word lookup.
  function automatic tok_state_t append(tok_state_t s, logic [7:0] c);
    tok_state_t r;
    r = s;
    if (s.tok_count < OFFSET_BITS'(KEYWORD_MAX_LEN)) begin
      r.prefix[s.tok_count[IdxW-1:0]] = c;
    end
    r.tok_count = off_inc(s.tok_count);
    return r;
  endfunction

  function automatic tok_state_t open_token(tok_state_t s, logic [2:0] kind,
                                            logic [7:0] c);
    tok_state_t r;
    r = clear_token(s);
    r.kind = kind;
    r.tok_start = s.pos;
    return append(r, c);
  endfunction

  // Result for the open token, with keyword and word-operator promotion.
  function automatic result_t finish_res(tok_state_t s);
    result_t    r;
    logic [63:0] text;
    logic [1:0] wc;
    for (int i = 0; i < KwMaxLen; i++) begin
      text[63-8*i -: 8] = s.prefix[i];
    end
    wc = word_class(text, s.tok_count[3:0]);
    r.kind = s.kind;
    if (s.tok_count <= OFFSET_BITS'(KwMaxLen)) begin
      if (wc == WORD_KEY) begin
        r.kind = KIND_KEYWORD;
      end else if (wc == WORD_OPER) begin
        r.kind = KIND_OPER;
      end
    end
    r.start = FieldOffW'(s.tok_start);
    r.len = FieldOffW'(s.tok_count);
    r.line = FieldLineW'(s.line);
    r.col = FieldLineW'(s.col);
    return r;
  endfunction

  // One character with its lookahead; yields at most one finished token.
  function automatic step_t proc_char(tok_state_t s, logic [7:0] c, logic [7:0] nx);
    step_t      r;
    logic [2:0] cls;
    logic       fin;
    r.st = s;
    r.emit = 1'b0;
    r.res = '0;
    cls = classify(c);
    fin = 1'b0;

    // A dash pair closes any open token and starts a comment.
    if (c == CHAR_DASH && nx == CHAR_DASH) begin
      if (r.st.kind != KIND_NONE) begin
        r.res = finish_res(r.st);
        r.emit = 1'b1;
        r.st = clear_token(r.st);
      end
      r.st.comment = 1'b1;
    end

    if (r.st.comment) begin
      // Comment bytes move the offset; a newline ends the comment and the line.
      if (c == CHAR_LF) begin
        r.st.line = line_inc(r.st.line);
        r.st.col = LINE_BITS'(1);
        r.st.kind = KIND_NONE;
        r.st.comment = 1'b0;
      end
      r.st.pos = off_inc(r.st.pos);
    end else begin
      // Extend or close the open token.
      case (r.st.kind)
        KIND_NAME: begin
          if (cls == CLS_TXT || cls == CLS_NUM) r.st = append(r.st, c);
          else fin = 1'b1;
        end
        KIND_NUM: begin
          if (cls == CLS_NUM || c == CHAR_DOT) r.st = append(r.st, c);
          else fin = 1'b1;
        end
        KIND_BRACKET: begin
          fin = 1'b1;
        end
        KIND_OPER: begin
          if (cls == CLS_OPER) r.st = append(r.st, c);
          else fin = 1'b1;
        end
        KIND_STRING: begin
          r.st = append(r.st, c);
          if (r.st.quote == c) fin = 1'b1;
        end
        default: begin
        end
      endcase
      if (fin) begin
        r.res = finish_res(r.st);
        r.emit = 1'b1;
        r.st = clear_token(r.st);
      end

      // Start a new token, or drop a quote left over from a cut string.
      if (r.st.kind == KIND_NONE) begin
        case (cls)
          CLS_TXT:     r.st = open_token(r.st, KIND_NAME, c);
          CLS_NUM:     r.st = open_token(r.st, KIND_NUM, c);
          CLS_BRACKET: r.st = open_token(r.st, KIND_BRACKET, c);
          CLS_OPER:    r.st = open_token(r.st, KIND_OPER, c);
          CLS_QUOTE: begin
            if (r.st.quote != CHAR_BLANK) begin
              r.st.quote = CHAR_BLANK;
            end else begin
              r.st.quote = c;
              r.st = open_token(r.st, KIND_STRING, c);
            end
          end
          default: begin
          end
        endcase
      end

      r.st.col = line_inc(r.st.col);
      if (c == CHAR_LF) begin
        r.st.line = line_inc(r.st.line);
        r.st.col = LINE_BITS'(1);
      end
      r.st.pos = off_inc(r.st.pos);
    end
    return r;
  endfunction

  // Input register.
  logic       in_full_q;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Tokenizer state and result bank.
  tok_state_t state_q, state_d;
  result_t    res_q [4];
  result_t    res_d [4];
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q;
  logic [1:0] last_idx;

  logic  out_acc;
  logic  bank_free;
  logic  load;
  step_t step_a, step_b;
  tok_state_t flush_st;
  result_t    end_res;

  assign last_idx = 2'(cnt_q - 3'd1);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc = out_valid_o && !out_stall_i;
  assign bank_free = (cnt_q == 3'd0) || (out_acc && idx_q == last_idx);
  assign load = in_full_q && bank_free;
  assign in_stall_o = in_full_q && !bank_free;

  // Work for one byte: the held byte, then on the final byte the flush.
  always_comb begin
    step_a = '0;
    step_a.st = state_q;
    step_b = '0;
    flush_st = '0;
    end_res = '0;
    cnt_d = 3'd0;
    for (int i = 0; i < 4; i++) res_d[i] = '0;

    if (state_q.held_valid) begin
      step_a = proc_char(state_q, state_q.held_char, in_char_q);
    end
    if (step_a.emit) begin
      res_d[cnt_d[1:0]] = step_a.res;
      cnt_d = cnt_d + 3'd1;
    end

    if (in_last_q) begin
      step_b = proc_char(step_a.st, in_char_q, CHAR_BLANK);
      if (step_b.emit) begin
        res_d[cnt_d[1:0]] = step_b.res;
        cnt_d = cnt_d + 3'd1;
      end
      flush_st = step_b.st;
      if (flush_st.kind != KIND_NONE) begin
        res_d[cnt_d[1:0]] = finish_res(flush_st);
        cnt_d = cnt_d + 3'd1;
      end
      end_res.kind = KIND_END;
      end_res.start = FieldOffW'(flush_st.pos);
      end_res.len = '0;
      end_res.line = FieldLineW'(flush_st.line);
      end_res.col = FieldLineW'(flush_st.col);
      res_d[cnt_d[1:0]] = end_res;
      cnt_d = cnt_d + 3'd1;
      state_d = state_init();
    end else begin
      state_d = step_a.st;
      state_d.held_char = in_char_q;
      state_d.held_valid = 1'b1;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_full_q <= 1'b1;
    end else if (bank_free) begin
      in_full_q <= 1'b0;
    end
  end

  // Input payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_char_q <= char_byte_i;
      in_last_q <= end_of_text_i;
    end
  end

  // Tokenizer state and result bank control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= state_init();
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load) begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= 2'd0;
    end else if (out_acc) begin
      if (idx_q == last_idx) begin
        cnt_q <= 3'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < 4; i++) res_q[i] <= res_d[i];
    end
  end

  // Current transaction.
  assign token_kind_o = res_q[idx_q].kind;
  assign start_offset_o = res_q[idx_q].start;
  assign token_length_o = res_q[idx_q].len;
  assign line_number_o = res_q[idx_q].line;
  assign column_number_o = res_q[idx_q].col;
  assign run_last_o = (idx_q == last_idx);

endmodule

`default_nettype wire

// ===== design/sttc_checker.sv =====
// Port-level checker for the source text tokenizer, bound to its core module.
// Depends on sttc_pkg and on source_text_tokenizer_core_macros.svh.
`default_nettype none

`include "source_text_tokenizer_core_macros.svh"

module sttc_checker import sttc_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic [7:0]            char_byte_i,
  input wire logic                  end_of_text_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [2:0]            token_kind_o,
  input wire logic [FieldOffW-1:0]  start_offset_o,
  input wire logic [FieldOffW-1:0]  token_length_o,
  input wire logic [FieldLineW-1:0] line_number_o,
  input wire logic [FieldLineW-1:0] column_number_o,
  input wire logic                  run_last_o
);

  // A stalled result transaction stays offered.
  `STTC_ASSERT(a_out_hold_valid, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // A stalled result transaction keeps its payload.
  `STTC_ASSERT(a_out_hold_data, out_valid_o && out_stall_i |=> $stable(token_kind_o) && $stable(start_offset_o) && $stable(token_length_o) && $stable(line_number_o) && $stable(column_number_o) && $stable(run_last_o), "stalled result changed")

  // A result that is not the last of its byte is followed by another one.
  `STTC_ASSERT(a_run_continues, out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o, "run of results cut short")

  // The end marker closes its run and has no length.
  `STTC_ASSERT(a_end_marker, out_valid_o && token_kind_o == KIND_END |-> run_last_o && token_length_o == '0, "malformed end marker")

  // Once reset has been seen at an edge, nothing is offered and nothing is stalled.
  `STTC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

bind source_text_tokenizer_core sttc_checker u_sttc_checker (.*);

`default_nettype wire
